[rtl/mhd_pkg.sv]
// shared types, codes and helpers for the min-heap block
`default_nettype none

package mhd_pkg;

  // field widths fixed by the request and result formats
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 7;

  // request opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD  = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,  // waiting for a request
    ST_RDOUT = 7'b0000010,  // read data returning
    ST_DLOAD = 7'b0000100,  // removed key and last key returning
    ST_DDIR  = 7'b0001000,  // choose sift direction after delete
    ST_UP    = 7'b0010000,  // one sift-up level per cycle
    ST_DOWN  = 7'b0100000,  // one sift-down level per cycle
    ST_FIN   = 7'b1000000   // place the moving key, report
  } state_e;

  // signed key compare
  function automatic logic key_less(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    return a < b;
  endfunction

endpackage

`default_nettype wire

[rtl/mhd_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module mhd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/min_heap_delete_at_index.sv]
// binary min-heap with insert, delete at slot and read slot
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+------------------------------
//  request   | opcode_i, value_i, slot_i            | taken when start && !busy
//  result    | data_o, status_o, fill_o             | valid_o high for one cycle
//
// a rejected request answers straight from idle, a read passes through the read-out
// state, an insert sifts up unless the heap was empty, and a delete loads the removed
// and last keys, ends there if the last slot was removed, and otherwise chooses a
// direction and sifts the moved key up or down one level at a time. the key store is
// mirrored in two rams so both children are read together, and the moving key stays
// in a register and is written once it settles.
// reset clears the fill count and the sequencer; the store needs no clearing pass.
// the receiver cannot stall: busy drops in the cycle the result is shown.
`default_nettype none

module min_heap_delete_at_index
  import mhd_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          opcode_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic [SLOT_W-1:0]        slot_i,
  output logic                          valid_o,
  output logic signed [DATA_W-1:0]      data_o,
  output logic [STAT_W-1:0]             status_o,
  output logic [FILL_W-1:0]             fill_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int unsigned XW = (CW > FILL_W) ? CW : FILL_W;
  localparam logic [CW-1:0] CAP_FILL = CW'(CAPACITY);

  state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] pos_q, pos_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic signed [DATA_W-1:0] rem_q, rem_d;
  logic del_q, del_d;
  logic out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;

  logic we;
  logic [AW-1:0] waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  logic signed [DATA_W-1:0] ra_data, rb_data;

  // parent slot of a nonzero position
  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] pm;
    pm = p - AW'(1);
    return pm >> 1;
  endfunction

  // left child position, wide enough to compare against the fill count
  function automatic logic [LW-1:0] left_of(input logic [AW-1:0] p);
    return LW'({p, 1'b1});
  endfunction

  // mirrored key store: both copies take every write
  mhd_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(ra_addr),
    .rdata_o(ra_data)
  );

  mhd_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rb_addr),
    .rdata_o(rb_data)
  );

  // request decode helpers
  logic accept;
  logic [SW-1:0] slot_x;
  logic slot_ok;
  logic [CW-1:0] fill_m1;
  assign accept  = start && !busy;
  assign slot_x  = SW'(slot_i);
  assign slot_ok = slot_x < SW'(fill_q);
  assign fill_m1 = fill_q - CW'(1);

  // sift-down helpers for the current position
  logic [LW-1:0] cl, cr;
  logic cl_ok, cr_ok;
  assign cl    = left_of(pos_q);
  assign cr    = cl + LW'(1);
  assign cl_ok = cl < LW'(fill_q);
  assign cr_ok = cr < LW'(fill_q);

  // best of key, left child and right child
  logic pick_l, pick_r;
  logic signed [DATA_W-1:0] lbest;
  logic [AW-1:0] best_pos;
  logic signed [DATA_W-1:0] best_val;
  logic [LW-1:0] bl;
  logic bl_ok;
  always_comb begin
    pick_l = key_less(ra_data, cur_q);
    lbest  = pick_l ? ra_data : cur_q;
    pick_r = cr_ok && key_less(rb_data, lbest);
    if (pick_r) begin
      best_pos = cr[AW-1:0];
      best_val = rb_data;
    end else begin
      best_pos = cl[AW-1:0];
      best_val = ra_data;
    end
  end
  assign bl    = left_of(best_pos);
  assign bl_ok = bl < LW'(fill_q);

  // sift-up helpers
  logic [AW-1:0] par, gpar;
  logic up_move;
  assign par     = parent_of(pos_q);
  assign gpar    = parent_of(par);
  assign up_move = (pos_q != '0) && key_less(cur_q, ra_data);

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    del_d        = del_q;
    out_valid_d  = 1'b0;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = cur_q;
    ra_addr      = pos_q;
    rb_addr      = pos_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_INSERT: begin
              if (fill_q >= CAP_FILL) begin
                out_valid_d  = 1'b1;
                out_data_d   = '0;
                out_status_d = STATUS_FULL;
              end else begin
                fill_d  = fill_q + CW'(1);
                pos_d   = fill_q[AW-1:0];
                cur_d   = value_i;
                del_d   = 1'b0;
                ra_addr = parent_of(fill_q[AW-1:0]);
                state_d = (fill_q == '0) ? ST_FIN : ST_UP;
              end
            end
            OP_DELETE: begin
              if (!slot_ok) begin
                out_valid_d  = 1'b1;
                out_data_d   = '0;
                out_status_d = STATUS_BAD;
              end else begin
                fill_d  = fill_m1;
                pos_d   = slot_x[AW-1:0];
                del_d   = 1'b1;
                ra_addr = slot_x[AW-1:0];
                rb_addr = fill_m1[AW-1:0];
                state_d = ST_DLOAD;
              end
            end
            OP_READ: begin
              if (!slot_ok) begin
                out_valid_d  = 1'b1;
                out_data_d   = '0;
                out_status_d = STATUS_BAD;
              end else begin
                ra_addr = slot_x[AW-1:0];
                state_d = ST_RDOUT;
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              out_data_d   = '0;
              out_status_d = STATUS_BAD;
            end
          endcase
        end
      end

      ST_RDOUT: begin
        out_valid_d  = 1'b1;
        out_data_d   = ra_data;
        out_status_d = STATUS_OK;
        state_d      = ST_IDLE;
      end

      ST_DLOAD: begin
        rem_d = ra_data;
        cur_d = rb_data;
        if (CW'(pos_q) == fill_q) begin
          // last slot removed, nothing moves
          out_valid_d  = 1'b1;
          out_data_d   = ra_data;
          out_status_d = STATUS_OK;
          state_d      = ST_IDLE;
        end else begin
          ra_addr = par;
          state_d = ST_DDIR;
        end
      end

      ST_DDIR: begin
        if (up_move) begin
          we      = 1'b1;
          wdata   = ra_data;
          pos_d   = par;
          ra_addr = gpar;
          state_d = (par == '0) ? ST_FIN : ST_UP;
        end else if (!cl_ok) begin
          state_d = ST_FIN;
        end else begin
          ra_addr = cl[AW-1:0];
          rb_addr = cr[AW-1:0];
          state_d = ST_DOWN;
        end
      end

      ST_UP: begin
        if (up_move) begin
          we      = 1'b1;
          wdata   = ra_data;
          pos_d   = par;
          ra_addr = gpar;
          state_d = (par == '0) ? ST_FIN : ST_UP;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_DOWN: begin
        if (pick_l || pick_r) begin
          we      = 1'b1;
          wdata   = best_val;
          pos_d   = best_pos;
          ra_addr = bl[AW-1:0];
          rb_addr = AW'(bl + LW'(1));
          state_d = bl_ok ? ST_DOWN : ST_FIN;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        we           = 1'b1;
        out_valid_d  = 1'b1;
        out_data_d   = del_q ? rem_q : '0;
        out_status_d = STATUS_OK;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    rem_q        <= rem_d;
    del_q        <= del_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  // outputs
  logic [XW-1:0] fill_x;
  assign fill_x   = XW'(fill_q);
  assign busy     = (state_q != ST_IDLE);
  assign valid_o  = out_valid_q;
  assign data_o   = out_data_q;
  assign status_o = out_status_q;
  assign fill_o   = fill_x[FILL_W-1:0];

  // checks
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while busy");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CAP_FILL)
    else $error("fill count beyond capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == STATUS_FULL)) |-> (fill_q == CAP_FILL))
    else $error("full status with room left");

  a_valid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy || start))
    else $error("result without a request");

endmodule

`default_nettype wire

[dv/heap_checker.sv]
// result checker for the min-heap block: shadow heap, expected-result queue, field compare
`timescale 1ns / 1ps

module heap_checker
  import mhd_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic [STAT_W-1:0]        status_i,
  input  logic [FILL_W-1:0]        fill_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill;
  } heap_result_t;

  // shadow copy of the heap and its fill count
  logic signed [DATA_W-1:0] keys [CAPACITY];
  int unsigned              count;
  int                       fails;

  // results still owed by the block, oldest first
  heap_result_t             owed_q [$];

  // append one expected result at the tail of the owed queue
  function automatic void queue_owed(heap_result_t res);
    owed_q.insert(owed_q.size(), res);
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    logic signed [DATA_W-1:0] tmp;
    tmp     = keys[i];
    keys[i] = keys[j];
    keys[j] = tmp;
  endfunction

  // move a key toward the root while strictly smaller than its parent
  function automatic void bubble_up(int unsigned pos);
    int unsigned par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!(keys[pos] < keys[par])) break;
      swap_keys(pos, par);
      pos = par;
    end
  endfunction

  // move a key toward the leaves; parent wins ties, then the left child
  function automatic void bubble_down(int unsigned pos);
    int unsigned lft;
    int unsigned rgt;
    int unsigned best;
    while (1) begin
      lft  = 2 * pos + 1;
      rgt  = lft + 1;
      best = pos;
      if (lft >= count) break;
      if (keys[lft] < keys[best]) best = lft;
      if (rgt < count && keys[rgt] < keys[best]) best = rgt;
      if (best == pos) break;
      swap_keys(pos, best);
      pos = best;
    end
  endfunction

  // apply one request to the shadow heap and give the result it should produce
  function automatic heap_result_t apply_heap_op(logic [OP_W-1:0]          op,
                                                 logic signed [DATA_W-1:0] val,
                                                 logic [SLOT_W-1:0]        slot);
    heap_result_t res;
    int unsigned  pos;
    res.data   = '0;
    res.status = STATUS_OK;
    pos        = slot;
    case (op)
      OP_INSERT: begin
        if (count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          keys[count] = val;
          count++;
          bubble_up(count - 1);
        end
      end
      OP_DELETE: begin
        if (pos >= count) begin
          res.status = STATUS_BAD;
        end else begin
          res.data = keys[pos];
          count--;
          // last key fills the hole unless the hole was the last slot
          if (pos != count) begin
            keys[pos] = keys[count];
            if (pos > 0 && keys[pos] < keys[(pos - 1) / 2]) bubble_up(pos);
            else bubble_down(pos);
          end
        end
      end
      OP_READ: begin
        if (pos >= count) res.status = STATUS_BAD;
        else res.data = keys[pos];
      end
      default: begin
        res.status = STATUS_BAD;
      end
    endcase
    res.fill = FILL_W'(count);
    return res;
  endfunction

  // results are matched before new requests are queued: a result never
  // belongs to a request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    heap_result_t want;
    if (!rst_ni) begin
      count = 0;
      fails = 0;
      owed_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result channel
      if (valid_i) begin
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual data %0d status %0d fill %0d",
                   $time, data_i, status_i, fill_i);
        end else begin
          want = owed_q.pop_front();
          if (data_i !== want.data) begin
            fails++;
            $display("%0t: data mismatch, expected %0d, actual %0d",
                     $time, $signed(want.data), data_i);
          end
          if (status_i !== want.status) begin
            fails++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
          if (fill_i !== want.fill) begin
            fails++;
            $display("%0t: fill mismatch, expected %0d, actual %0d",
                     $time, want.fill, fill_i);
          end
        end
      end
      // request channel
      if (start_i && !busy_i) begin
        queue_owed(apply_heap_op(opcode_i, value_i, slot_i));
      end
      fail_count_o <= fails;
      pending_o    <= owed_q.size();
    end
  end

endmodule

[dv/tb.sv]
// testbench top for the min-heap block: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import mhd_pkg::*;

  localparam int unsigned     CAPACITY        = 64;
  localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
  localparam int              ITEMS_PER_PHASE = 384;
  localparam int              CYCLE_LIMIT     = 400000;
  localparam int              DRAIN_CYCLES    = 16;

  logic                     clk_i    = 1'b0;
  logic                     rst_ni   = 1'b0;
  logic                     start    = 1'b0;
  logic [OP_W-1:0]          opcode_i = OP_INSERT;
  logic signed [DATA_W-1:0] value_i  = '0;
  logic [SLOT_W-1:0]        slot_i   = '0;
  logic                     busy;
  logic                     valid_o;
  logic signed [DATA_W-1:0] data_o;
  logic [STAT_W-1:0]        status_o;
  logic [FILL_W-1:0]        fill_o;
  int                       fail_count;
  int                       pending;
  int                       cycle_count = 0;
  int                       heap_fill   = 0;

  always #1 clk_i = ~clk_i;

  min_heap_delete_at_index #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .opcode_i(opcode_i),
    .value_i (value_i),
    .slot_i  (slot_i),
    .valid_o (valid_o),
    .data_o  (data_o),
    .status_o(status_o),
    .fill_o  (fill_o)
  );

  heap_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .slot_i      (slot_i),
    .valid_i     (valid_o),
    .data_i      (data_o),
    .status_i    (status_o),
    .fill_i      (fill_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one request and hold it until taken; keeps a rough fill count for slot choice
  task automatic send_request(input logic [OP_W-1:0]          op,
                              input logic signed [DATA_W-1:0] val,
                              input logic [SLOT_W-1:0]        slot);
    start    <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    slot_i   <= slot;
    do @(posedge clk_i); while (busy);
    case (op)
      OP_INSERT: begin
        if (heap_fill < CAPACITY) heap_fill++;
      end
      OP_DELETE: begin
        if (slot < heap_fill) heap_fill--;
      end
      default: ;
    endcase
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int                       idle_pct [3];
    int                       pick;
    bit                       filling;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    logic [SLOT_W-1:0]        slot;

    idle_pct = '{0, 83, 9};
    filling  = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty heap, extremes, ties, last slot, root, middle, out of range
    send_request(OP_READ, 32'sd0, 6'd0);
    send_request(OP_DELETE, 32'sd0, 6'd0);
    send_request(OP_UNUSED, '1, 6'd63);
    send_request(OP_INSERT, 32'sh7FFF_FFFF, 6'd0);
    send_request(OP_INSERT, 32'sh8000_0000, 6'd0);
    send_request(OP_INSERT, 32'sd0, 6'd0);
    send_request(OP_INSERT, -32'sd1, 6'd0);
    send_request(OP_INSERT, 32'sd5, 6'd0);
    send_request(OP_INSERT, 32'sd5, 6'd0);
    send_request(OP_READ, 32'sd0, 6'd0);
    send_request(OP_READ, 32'sd0, 6'd5);
    send_request(OP_READ, 32'sd0, 6'd6);
    send_request(OP_READ, 32'sd0, 6'd63);
    send_request(OP_DELETE, 32'sd0, 6'd5);
    send_request(OP_DELETE, 32'sd0, 6'd0);
    send_request(OP_INSERT, 32'sd5, 6'd0);
    send_request(OP_DELETE, 32'sd0, 6'd1);
    send_request(OP_INSERT, -32'sd5, 6'd0);
    send_request(OP_INSERT, 32'sd100, 6'd0);
    send_request(OP_DELETE, 32'sd0, 6'd2);
    send_request(OP_DELETE, 32'sd0, 6'd63);
    send_request(OP_READ, 32'sd0, 6'd0);
    wait_drained();

    // random: fill toward capacity, then drain toward empty, with random turns
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (heap_fill >= CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
        if (heap_fill == 0 && $urandom_range(1) == 1) filling = 1'b1;
        if ($urandom_range(199) == 0) filling = !filling;

        // opcode
        pick = $urandom_range(99);
        if (pick < 3) op = OP_UNUSED;
        else if (pick < (filling ? 63 : 18)) op = OP_INSERT;
        else if (pick < (filling ? 80 : 78)) op = OP_DELETE;
        else op = OP_READ;

        // key: full range, small ties, extremes, moderate spread
        pick = $urandom_range(99);
        if (pick < 40) begin
          val = $urandom;
        end else if (pick < 70) begin
          val = int'($urandom_range(16)) - 8;
        end else if (pick < 85) begin
          case ($urandom_range(3))
            0: val = {1'b0, {(DATA_W-1){1'b1}}};
            1: val = {1'b1, {(DATA_W-1){1'b0}}};
            2: val = '0;
            default: val = '1;
          endcase
        end else begin
          val = int'($urandom_range(2000)) - 1000;
        end

        // slot: mostly a live position, sometimes anywhere
        if (heap_fill > 0 && $urandom_range(99) < 85) begin
          slot = SLOT_W'($urandom_range(heap_fill - 1));
        end else begin
          slot = SLOT_W'($urandom_range(63));
        end

        send_request(op, val, slot);
        if ($urandom_range(99) < idle_pct[ph]) hold_off($urandom_range(12, 1));
      end
      wait_drained();
    end

    hold_off(DRAIN_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mhd_pkg.sv
rtl/mhd_ram.sv
rtl/min_heap_delete_at_index.sv
dv/heap_checker.sv
dv/tb.sv
